// ----- sv/spc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types for the scanline pixel compositor.
// Depends on nothing; imported by the top level and the testbench.
package spc_pkg;

   // Frame geometry and color RAM size
   localparam int FRAME_WIDTH   = 320;
   localparam int COLOR_ENTRIES = 64;
   localparam int COLOR_AW      = $clog2(COLOR_ENTRIES);
   localparam int COLOR_W       = 9;

   localparam int WIDE_COLUMNS   = 320;
   localparam int NARROW_COLUMNS = 256;
   localparam int WIDE_OFFSET    = (FRAME_WIDTH - WIDE_COLUMNS) / 2;
   localparam int NARROW_OFFSET  = (FRAME_WIDTH - NARROW_COLUMNS) / 2;

   localparam int TALL_LINES  = 240;
   localparam int SHORT_LINES = 224;

   // Request and response payload widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 24;

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      CSR_BACKDROP_INDEX    = 3'd0,
      CSR_WIDE_MODE         = 3'd1,
      CSR_TALL_MODE         = 3'd2,
      CSR_SHADOW_HIGHLIGHT  = 3'd3,
      CSR_DISPLAY_BLANK     = 3'd4,
      CSR_PLANES_ON         = 3'd5,
      CSR_WINDOW_VERTICAL   = 3'd6,
      CSR_WINDOW_HORIZONTAL = 3'd7
   } csr_index_type;

   // Request kinds carried on tuser
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Layer byte bits
   localparam int PRI_BIT = 7;
   localparam int HI_BIT  = 6;
   localparam logic [7:0] PRI_MASK = 8'h80;
   localparam logic [7:0] HI_MASK  = 8'h40;
   localparam logic [7:0] IDX_MASK = 8'h3F;

   // Sprite color codes with special meaning under shadow/highlight
   localparam logic [5:0] SPR_FORCE_NORMAL_0 = 6'h0E;
   localparam logic [5:0] SPR_FORCE_NORMAL_1 = 6'h1E;
   localparam logic [5:0] SPR_FORCE_NORMAL_2 = 6'h2E;
   localparam logic [5:0] SPR_HIGHLIGHT      = 6'h3E;
   localparam logic [5:0] SPR_SHADOW         = 6'h3F;

   // Pixel carried from the mix stage to the color stage
   typedef struct packed {
      logic       blank;
      logic       shi;
      logic [7:0] pix;
   } pix_info_type;

   // Widen a 3-bit channel to 8 bits by bit replication
   function automatic logic [7:0] widen3(input logic [2:0] c);
      return {c, c, c[2:1]};
   endfunction

endpackage

// ----- sv/spc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module spc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/scanline_pixel_compositor.sv -----
`timescale 1ns / 1ps
// Top level of the scanline pixel compositor: layer mix, color lookup, output.
// Depends on spc_pkg and spc_ram.

// The compositor takes one request per clock, back to back, unless it stalls:
// a write request stores a 9-bit color into the 64-entry color RAM, a pixel
// request mixes background plane B, plane A or the window plane, and the
// sprite layer for one column and returns one RGB888 response (none for
// lines below the visible height). A pixel request's response reaches rsp_tdata
// through the color RAM's registered read and then the output register. The
// color RAM reads as all zero after reset through per-entry valid bits, so there
// is no clearing pass and requests are taken right after reset. Requests are
// answered strictly in order; when the response side stalls, the block keeps
// taking requests until the mix stage and the output register are both full.
// Configuration registers sit on an APB-style port at byte address 4*i and
// are meant to be written only while no pixel request is in flight.
module scanline_pixel_compositor (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata from bit 0: color_slot[5:0], color_word[17:6], line[25:18],
   // column[34:26], plane_b_pixel[42:35], plane_a_pixel[50:43],
   // window_pixel[58:51], sprite_pixel[66:59], zero fill[71:67]
   input  logic [spc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser from bit 0: command (0 color write, 1 pixel)
   input  logic                             req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata from bit 0: red[7:0], green[15:8], blue[23:16]
   output logic [spc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [spc_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [spc_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [spc_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                             csr_pready
);

   import spc_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [5:0] backdrop_ff,  backdrop_in;
   logic       wide_ff,      wide_in;
   logic       tall_ff,      tall_in;
   logic       shi_ff,       shi_in;
   logic       blank_ff,     blank_in;
   logic       planes_ff,    planes_in;
   logic [7:0] win_vert_ff,  win_vert_in;
   logic [7:0] win_horz_ff,  win_horz_in;

   logic          csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:2]);

   // Decode the write
   always_comb begin
      backdrop_in = backdrop_ff;
      wide_in     = wide_ff;
      tall_in     = tall_ff;
      shi_in      = shi_ff;
      blank_in    = blank_ff;
      planes_in   = planes_ff;
      win_vert_in = win_vert_ff;
      win_horz_in = win_horz_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BACKDROP_INDEX:    backdrop_in = csr_pwdata[5:0];
            CSR_WIDE_MODE:         wide_in     = csr_pwdata[0];
            CSR_TALL_MODE:         tall_in     = csr_pwdata[0];
            CSR_SHADOW_HIGHLIGHT:  shi_in      = csr_pwdata[0];
            CSR_DISPLAY_BLANK:     blank_in    = csr_pwdata[0];
            CSR_PLANES_ON:         planes_in   = csr_pwdata[0];
            CSR_WINDOW_VERTICAL:   win_vert_in = csr_pwdata[7:0];
            CSR_WINDOW_HORIZONTAL: win_horz_in = csr_pwdata[7:0];
            default:               backdrop_in = backdrop_ff;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_BACKDROP_INDEX:    csr_prdata = CSR_DW'(backdrop_ff);
         CSR_WIDE_MODE:         csr_prdata = CSR_DW'(wide_ff);
         CSR_TALL_MODE:         csr_prdata = CSR_DW'(tall_ff);
         CSR_SHADOW_HIGHLIGHT:  csr_prdata = CSR_DW'(shi_ff);
         CSR_DISPLAY_BLANK:     csr_prdata = CSR_DW'(blank_ff);
         CSR_PLANES_ON:         csr_prdata = CSR_DW'(planes_ff);
         CSR_WINDOW_VERTICAL:   csr_prdata = CSR_DW'(win_vert_ff);
         CSR_WINDOW_HORIZONTAL: csr_prdata = CSR_DW'(win_horz_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backdrop_ff <= '0;
         wide_ff     <= 1'b0;
         tall_ff     <= 1'b0;
         shi_ff      <= 1'b0;
         blank_ff    <= 1'b0;
         planes_ff   <= 1'b0;
         win_vert_ff <= '0;
         win_horz_ff <= '0;
      end else begin
         backdrop_ff <= backdrop_in;
         wide_ff     <= wide_in;
         tall_ff     <= tall_in;
         shi_ff      <= shi_in;
         blank_ff    <= blank_in;
         planes_ff   <= planes_in;
         win_vert_ff <= win_vert_in;
         win_horz_ff <= win_horz_in;
      end
   end

   // ------------------------------------------------------------------
   // Request fields
   // ------------------------------------------------------------------
   logic [5:0]  color_slot;
   logic [11:0] color_word;
   logic [7:0]  line;
   logic [8:0]  column;
   logic [7:0]  pb, pa, pw, ps;

   // Drop bit 6 of every layer byte: it carries no meaning
   assign color_slot = req_tdata[5:0];
   assign color_word = req_tdata[17:6];
   assign line       = req_tdata[25:18];
   assign column     = req_tdata[34:26];
   assign pb         = req_tdata[42:35] & ~HI_MASK;
   assign pa         = req_tdata[50:43] & ~HI_MASK;
   assign pw         = req_tdata[58:51] & ~HI_MASK;
   assign ps         = req_tdata[66:59] & ~HI_MASK;

   // ------------------------------------------------------------------
   // Handshake and pipeline control
   // ------------------------------------------------------------------
   logic         s1_vld_ff, s1_vld_in;
   pix_info_type s1_info_ff, s1_info_in;
   logic         s1_hit_ff, s1_hit_in;
   logic         rsp_vld_ff, rsp_vld_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic out_free;
   logic req_fire;
   logic is_pixel;
   logic visible;
   logic s1_load;
   logic ram_wr;

   // The output register frees when empty or taken; the mix stage then moves.
   assign out_free   = ~rsp_vld_ff | rsp_tready;
   assign req_tready = ~s1_vld_ff | out_free;
   assign req_fire   = req_tvalid & req_tready;
   assign is_pixel   = (req_tuser == CMD_PIXEL);
   assign visible    = {1'b0, line} < (tall_ff ? 9'(TALL_LINES) : 9'(SHORT_LINES));
   assign s1_load    = req_fire & is_pixel & visible;
   assign ram_wr     = req_fire & ~is_pixel;

   // ------------------------------------------------------------------
   // Mix stage: active area, window test and layer priority
   // ------------------------------------------------------------------
   logic signed [10:0] x_pos;
   logic [8:0]         x9;
   logic [8:0]         width;
   logic               active;
   logic               win_hit;
   logic [7:0]         aw;
   logic [7:0]         back;
   logic [7:0]         tile;
   logic [7:0]         mixed;
   logic [5:0]         spr_code;

   assign width = wide_ff ? 9'(WIDE_COLUMNS) : 9'(NARROW_COLUMNS);
   assign x_pos = $signed({2'b00, column})
                - (wide_ff ? 11'(WIDE_OFFSET) : 11'(NARROW_OFFSET));
   assign x9    = x_pos[8:0];

   assign active = ({1'b0, column} < 10'(FRAME_WIDTH)) && !x_pos[10]
                 && (x_pos < $signed({2'b00, width})) && planes_ff;

   // Window region: rows past or before the vertical mark, columns likewise
   always_comb begin
      logic [7:0] vb;
      logic [8:0] hb;
      logic       v_hit;
      logic       h_hit;
      vb    = {win_vert_ff[4:0], 3'b000};
      hb    = {win_horz_ff[4:0], 4'b0000};
      v_hit = win_vert_ff[7] ? (line >= vb) : (line < vb);
      h_hit = win_horz_ff[7] ? (x9 >= hb) : (x9 < hb);
      win_hit = v_hit | h_hit;
   end

   assign aw       = win_hit ? pw : pa;
   assign back     = {2'b00, backdrop_ff};
   assign spr_code = ps[5:0];

   always_comb begin
      tile = back;
      if (pb[3:0] != 4'd0) begin
         tile = pb;
      end
      if ((aw[3:0] != 4'd0) && (tile[PRI_BIT] <= aw[PRI_BIT])) begin
         tile = aw;
      end
      if ((ps[3:0] != 4'd0) && (tile[PRI_BIT] <= ps[PRI_BIT])) begin
         mixed = ps;
         if (shi_ff) begin
            case (spr_code)
               SPR_FORCE_NORMAL_0,
               SPR_FORCE_NORMAL_1,
               SPR_FORCE_NORMAL_2: mixed = ps | PRI_MASK;
               SPR_HIGHLIGHT:      mixed = tile | HI_MASK;
               SPR_SHADOW:         mixed = tile & IDX_MASK;
               default:            mixed = ps;
            endcase
         end
      end else begin
         // Under shadow/highlight a priority tile on either plane keeps normal
         mixed = shi_ff ? (tile | ((pb | aw) & PRI_MASK)) : tile;
      end
   end

   // ------------------------------------------------------------------
   // Color RAM with per-entry valid bits standing in for the reset clear
   // ------------------------------------------------------------------
   logic [COLOR_ENTRIES-1:0] valid_ff, valid_in;
   logic [COLOR_AW-1:0]      rd_addr;
   logic [COLOR_W-1:0]       ram_wr_data;
   logic [COLOR_W-1:0]       ram_rd_data;

   assign ram_wr_data = {color_word[11:9], color_word[7:5], color_word[3:1]};

   always_comb begin
      s1_info_in.blank = blank_ff;
      s1_info_in.shi   = shi_ff;
      s1_info_in.pix   = active ? mixed : back;
   end

   assign rd_addr = s1_info_in.pix[COLOR_AW-1:0];

   spc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (COLOR_ENTRIES)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (color_slot),
      .wr_data (ram_wr_data),
      .rd_en   (s1_load),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (ram_wr) begin
         valid_in[color_slot] = 1'b1;
      end
   end

   // Capture the entry's valid bit alongside the read
   assign s1_hit_in = s1_load ? valid_ff[rd_addr] : s1_hit_ff;

   always_comb begin
      if (req_fire) begin
         s1_vld_in = s1_load;
      end else if (out_free) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   // ------------------------------------------------------------------
   // Color stage: widen channels, apply shadow or highlight, blank
   // ------------------------------------------------------------------
   logic [COLOR_W-1:0] rgb;
   logic [7:0]         red, green, blue;

   always_comb begin
      rgb   = s1_hit_ff ? ram_rd_data : '0;
      red   = widen3(rgb[2:0]);
      green = widen3(rgb[5:3]);
      blue  = widen3(rgb[8:6]);
      if (s1_info_ff.shi) begin
         if (s1_info_ff.pix[HI_BIT]) begin
            red   = {1'b1, red[7:1]};
            green = {1'b1, green[7:1]};
            blue  = {1'b1, blue[7:1]};
         end else if (!s1_info_ff.pix[PRI_BIT]) begin
            red   = {1'b0, red[7:1]};
            green = {1'b0, green[7:1]};
            blue  = {1'b0, blue[7:1]};
         end
      end
      if (s1_info_ff.blank) begin
         red   = '0;
         green = '0;
         blue  = '0;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (out_free) begin
         rsp_vld_in  = s1_vld_ff;
         rsp_data_in = {blue, green, red};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         valid_ff   <= valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_info_ff <= s1_info_in;
      end
      s1_hit_ff   <= s1_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   // A color write marks its entry valid for all later reads
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ram_wr |=> valid_ff[$past(color_slot)])
      else $error("color write did not mark its entry valid");

   // A stalled mix stage must hold off new requests so the RAM output holds
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_free) |-> !req_tready)
      else $error("request taken while mix stage stalled");

   // A blanked pixel leaves as black
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_free && s1_info_ff.blank) |=> (rsp_tdata == '0))
      else $error("blanked pixel not black");

   // A pixel in the mix stage reaches the output register when it frees
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_free) |=> rsp_tvalid)
      else $error("mix stage result lost");

   // Nothing is presented straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");
`endif

endmodule

// ----- verif/tb_scanline_pixel_compositor.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for scanline_pixel_compositor: request driver,
// response monitor, APB register writes and an in-bench pixel predictor.
// Depends on spc_pkg and the compositor RTL.
module tb_scanline_pixel_compositor;
   import spc_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int DRAIN_CYCLES    = 4;
   localparam int END_CYCLES      = 10;
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any handshake
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int PRESSURE_AFTER  = 120;   // responses seen before the long hold
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int PRINT_LIMIT     = 20;

   // One request as the bench sees it, before packing onto tdata
   typedef struct {
      logic       cmd;
      logic [5:0] slot;
      logic [11:0] word;
      logic [7:0] line_no;
      logic [8:0] column;
      logic [7:0] plane_b;
      logic [7:0] plane_a;
      logic [7:0] window_px;
      logic [7:0] sprite;
   } compositor_request_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   // DUT connections; every input starts at a known value
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr   = '0;
   logic [CSR_DW-1:0]      csr_pwdata  = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // Predictor state: register copies and the color RAM image
   logic [5:0] cfg_backdrop = '0;
   logic       cfg_wide     = 1'b0;
   logic       cfg_tall     = 1'b0;
   logic       cfg_shi      = 1'b0;
   logic       cfg_blank    = 1'b0;
   logic       cfg_planes   = 1'b0;
   logic [7:0] cfg_wv       = '0;
   logic [7:0] cfg_wh       = '0;
   logic [8:0] palette [COLOR_ENTRIES];

   compositor_request_type request_queue [$];
   rgb_pixel_type          awaited_pixels [$];

   // Bench bookkeeping
   compositor_request_type current_req;
   rgb_pixel_type          want;
   int  mismatches     = 0;
   int  color_writes   = 0;
   int  hidden_lines   = 0;
   int  pixels_checked = 0;
   int  input_stalls   = 0;
   int  settings_used  = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;
   int  silent_cycles  = 0;
   int  idle_percent   = 0;
   int  stall_percent  = 0;
   bit  quiet          = 1'b0;

   scanline_pixel_compositor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Replicate a 3-bit channel up to 8 bits, then apply shadow or highlight
   function automatic logic [7:0] to_screen(input logic [2:0] c, input logic [7:0] pix);
      logic [7:0] v;
      v = ({5'b0, c} << 5) | ({5'b0, c} << 2) | ({5'b0, c} >> 1);
      if (cfg_shi) begin
         if (pix[HI_BIT])
            v = (v >> 1) | 8'h80;
         else if (!pix[PRI_BIT])
            v = v >> 1;
      end
      return v;
   endfunction

   // Window region: either the line test or the column test hits
   function automatic bit window_region_hit(input int x, input int y);
      int rows;
      int cols;
      rows = int'(cfg_wv[4:0]) * 8;
      cols = int'(cfg_wh[4:0]) * 16;
      if (cfg_wv[7] ? (y >= rows) : (y < rows))
         return 1'b1;
      return cfg_wh[7] ? (x >= cols) : (x < cols);
   endfunction

   // Priority mix; result bit 7 marks normal, bit 6 highlight, 5..0 the index
   function automatic logic [7:0] mix_layers(input logic [7:0] b, input logic [7:0] a,
                                             input logic [7:0] s);
      logic [7:0] tile;
      logic [5:0] code;
      tile = {2'b00, cfg_backdrop};
      code = s[5:0];
      if (b[3:0] != 4'h0)
         tile = b;
      if (a[3:0] != 4'h0 && tile[PRI_BIT] <= a[PRI_BIT])
         tile = a;
      if (s[3:0] != 4'h0 && tile[PRI_BIT] <= s[PRI_BIT]) begin
         if (cfg_shi) begin
            // these sprite codes force a normal pixel, a highlight or a shadow
            if (code == SPR_FORCE_NORMAL_0 || code == SPR_FORCE_NORMAL_1 ||
                code == SPR_FORCE_NORMAL_2)
               return s | PRI_MASK;
            if (code == SPR_HIGHLIGHT)
               return tile | HI_MASK;
            if (code == SPR_SHADOW)
               return tile & IDX_MASK;
         end
         return s;
      end
      // a priority tile on either plane lifts the pixel out of shadow
      if (cfg_shi)
         tile = tile | ((b | a) & PRI_MASK);
      return tile;
   endfunction

   // Advance the predictor by one accepted request; queue the pixel it yields
   function automatic void compose_expected_pixel(input compositor_request_type r);
      int         visible;
      int         width;
      int         x;
      logic [7:0] pix;
      logic [7:0] front;
      logic [8:0] entry;
      rgb_pixel_type p;
      if (r.cmd == CMD_WRITE) begin
         palette[r.slot] = {r.word[11:9], r.word[7:5], r.word[3:1]};
         color_writes++;
         return;
      end
      visible = cfg_tall ? TALL_LINES : SHORT_LINES;
      if (int'(r.line_no) >= visible) begin
         hidden_lines++;
         return;
      end
      if (cfg_blank) begin
         p = '{8'h00, 8'h00, 8'h00};
         awaited_pixels.push_back(p);
         return;
      end
      width = cfg_wide ? WIDE_COLUMNS : NARROW_COLUMNS;
      x     = int'(r.column) - (FRAME_WIDTH - width) / 2;
      pix   = {2'b00, cfg_backdrop};
      if (int'(r.column) < FRAME_WIDTH && x >= 0 && x < width && cfg_planes) begin
         // bit 6 of every layer byte carries no meaning: clear it first
         front = window_region_hit(x, int'(r.line_no)) ? r.window_px : r.plane_a;
         pix   = mix_layers(r.plane_b & ~HI_MASK, front & ~HI_MASK, r.sprite & ~HI_MASK);
      end
      entry   = palette[pix[5:0]];
      p.red   = to_screen(entry[2:0], pix);
      p.green = to_screen(entry[5:3], pix);
      p.blue  = to_screen(entry[8:6], pix);
      awaited_pixels.push_back(p);
   endfunction

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------

   function automatic compositor_request_type make_write(input logic [5:0] slot,
                                                         input logic [11:0] word);
      compositor_request_type r;
      r.cmd       = CMD_WRITE;
      r.slot      = slot;
      r.word      = word;
      // the pixel fields are don't-care here: fill them with noise
      r.line_no   = 8'($urandom);
      r.column    = 9'($urandom);
      r.plane_b   = 8'($urandom);
      r.plane_a   = 8'($urandom);
      r.window_px = 8'($urandom);
      r.sprite    = 8'($urandom);
      return r;
   endfunction

   function automatic compositor_request_type make_pixel(input logic [7:0] line_no,
         input logic [8:0] column, input logic [7:0] b, input logic [7:0] a,
         input logic [7:0] w, input logic [7:0] s);
      compositor_request_type r;
      r.cmd       = CMD_PIXEL;
      r.slot      = 6'($urandom);
      r.word      = 12'($urandom);
      r.line_no   = line_no;
      r.column    = column;
      r.plane_b   = b;
      r.plane_a   = a;
      r.window_px = w;
      r.sprite    = s;
      return r;
   endfunction

   // Random layer byte, transparent about a third of the time
   function automatic logic [7:0] random_layer();
      logic [7:0] v;
      v = 8'($urandom);
      if ($urandom_range(0, 2) == 0)
         v[3:0] = 4'h0;
      return v;
   endfunction

   // Sprite byte that lands on one of the special codes a quarter of the time
   function automatic logic [7:0] random_sprite();
      logic [5:0] code;
      if ($urandom_range(0, 3) != 0)
         return random_layer();
      case ($urandom_range(0, 4))
         0:       code = SPR_FORCE_NORMAL_0;
         1:       code = SPR_FORCE_NORMAL_1;
         2:       code = SPR_FORCE_NORMAL_2;
         3:       code = SPR_HIGHLIGHT;
         default: code = SPR_SHADOW;
      endcase
      return {1'($urandom), 1'($urandom), code};
   endfunction

   // Mostly visible lines inside the active width; the rest anywhere
   function automatic compositor_request_type random_pixel();
      int visible;
      int width;
      int first;
      logic [7:0] line_no;
      logic [8:0] column;
      visible = cfg_tall ? TALL_LINES : SHORT_LINES;
      width   = cfg_wide ? WIDE_COLUMNS : NARROW_COLUMNS;
      first   = (FRAME_WIDTH - width) / 2;
      line_no = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, visible - 1));
      column  = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(first, first + width - 1));
      return make_pixel(line_no, column, random_layer(), random_layer(),
                        random_layer(), random_sprite());
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: hold each request until taken, then maybe idle a burst
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            compose_expected_pixel(current_req);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               current_req = request_queue.pop_front();
               req_tdata  <= {5'b0, current_req.sprite, current_req.window_px,
                              current_req.plane_a, current_req.plane_b,
                              current_req.column, current_req.line_no,
                              current_req.word, current_req.slot};
               req_tuser  <= current_req.cmd;
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(1, 100) <= idle_percent)
                  send_gap = $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and receiver backpressure
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_tready)
            input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            pixels_checked++;
            if (awaited_pixels.size() == 0) begin
               report_mismatch($sformatf("response %06h with no pixel awaited", rsp_tdata));
            end else begin
               want = awaited_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.red)
                  report_mismatch($sformatf("red %02h, want %02h", rsp_tdata[7:0], want.red));
               if (rsp_tdata[15:8] !== want.green)
                  report_mismatch($sformatf("green %02h, want %02h",
                                            rsp_tdata[15:8], want.green));
               if (rsp_tdata[23:16] !== want.blue)
                  report_mismatch($sformatf("blue %02h, want %02h",
                                            rsp_tdata[23:16], want.blue));
            end
         end
         // Hold off once for a long stretch while requests are still offered,
         // so the mix stage and output register fill and req_tready drops.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && pixels_checked >= PRESSURE_AFTER && req_tvalid) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(1, 100) <= stall_percent) begin
            recv_gap = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Register access and sequencing
   // ---------------------------------------------------------------------

   // APB write: setup, then access; junk in the bits above the register width
   task automatic write_register(input csr_index_type idx, input logic [7:0] value);
      logic [31:0] keep;
      case (idx)
         CSR_BACKDROP_INDEX:                           keep = 32'h3F;
         CSR_WINDOW_VERTICAL, CSR_WINDOW_HORIZONTAL:   keep = 32'hFF;
         default:                                      keep = 32'h01;
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(int'(idx) * 4);
      csr_pwdata  <= ($urandom() & ~keep) | ({24'b0, value} & keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_BACKDROP_INDEX:    cfg_backdrop = value[5:0];
         CSR_WIDE_MODE:         cfg_wide     = value[0];
         CSR_TALL_MODE:         cfg_tall     = value[0];
         CSR_SHADOW_HIGHLIGHT:  cfg_shi      = value[0];
         CSR_DISPLAY_BLANK:     cfg_blank    = value[0];
         CSR_PLANES_ON:         cfg_planes   = value[0];
         CSR_WINDOW_VERTICAL:   cfg_wv       = value;
         CSR_WINDOW_HORIZONTAL: cfg_wh       = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [5:0] backdrop, input logic wide, input logic tall,
                            input logic shi, input logic blank, input logic planes,
                            input logic [7:0] wv, input logic [7:0] wh);
      write_register(CSR_BACKDROP_INDEX, {2'b00, backdrop});
      write_register(CSR_WIDE_MODE, {7'b0, wide});
      write_register(CSR_TALL_MODE, {7'b0, tall});
      write_register(CSR_SHADOW_HIGHLIGHT, {7'b0, shi});
      write_register(CSR_DISPLAY_BLANK, {7'b0, blank});
      write_register(CSR_PLANES_ON, {7'b0, planes});
      write_register(CSR_WINDOW_VERTICAL, wv);
      write_register(CSR_WINDOW_HORIZONTAL, wh);
      settings_used++;
      @(negedge clock);
   endtask

   // Wait for every request taken and every pixel back, then let the pipe empty
   task automatic wait_until_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_tvalid || awaited_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      foreach (palette[i])
         palette[i] = '0;
      idle_percent  = 20;
      stall_percent = 20;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state: planes off, 224 lines, 256 centered columns, backdrop 0
      request_queue.push_back(make_write(6'd0, 12'hFFF));
      request_queue.push_back(make_pixel(8'd0, 9'd0, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd223, 9'd160, 8'h05, 8'h06, 8'h07, 8'h08));
      request_queue.push_back(make_pixel(8'd224, 9'd160, 8'h05, 8'h06, 8'h07, 8'h08));
      request_queue.push_back(make_pixel(8'd255, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

      // Load the whole color RAM with random colors
      for (int i = 0; i < COLOR_ENTRIES; i++)
         request_queue.push_back(make_write(6'(i), 12'($urandom)));
      wait_until_drained();

      // Directed mixing cases: window from line 40 down or left of x 64
      configure(6'd63, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h85, 8'h04);
      request_queue.push_back(make_write(6'd63, 12'h000));
      request_queue.push_back(make_write(6'd1, 12'hFFF));
      // outside the active width and past the frame: shadowed backdrop
      request_queue.push_back(make_pixel(8'd0, 9'd31, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd0, 9'd288, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd0, 9'd511, 8'h81, 8'h82, 8'h83, 8'h84));
      // first and last active column, last visible line, inside window
      request_queue.push_back(make_pixel(8'd223, 9'd32, 8'h81, 8'h00, 8'h00, 8'h00));
      request_queue.push_back(make_pixel(8'd10, 9'd287, 8'h01, 8'h92, 8'h00, 8'h00));
      request_queue.push_back(make_pixel(8'd10, 9'd40, 8'h00, 8'h13, 8'h24, 8'h00));
      // sprite codes that force normal, highlight and shadow
      request_queue.push_back(make_pixel(8'd5, 9'd100, 8'h05, 8'h00, 8'h00, 8'h0E));
      request_queue.push_back(make_pixel(8'd5, 9'd100, 8'h05, 8'h00, 8'h00, 8'h1E));
      request_queue.push_back(make_pixel(8'd5, 9'd100, 8'h05, 8'h00, 8'h00, 8'h2E));
      request_queue.push_back(make_pixel(8'd5, 9'd100, 8'h05, 8'h00, 8'h00, 8'h3E));
      request_queue.push_back(make_pixel(8'd5, 9'd100, 8'h05, 8'h00, 8'h00, 8'h3F));
      // low-priority sprite under a priority tile; meaningless bit 6 set
      request_queue.push_back(make_pixel(8'd50, 9'd200, 8'h83, 8'h00, 8'h00, 8'h07));
      request_queue.push_back(make_pixel(8'd50, 9'd200, 8'hC5, 8'h4A, 8'h00, 8'hFF));
      // every layer transparent, then every layer all ones
      request_queue.push_back(make_pixel(8'd50, 9'd200, 8'hF0, 8'h70, 8'h30, 8'hB0));
      request_queue.push_back(make_pixel(8'd50, 9'd200, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // lines beyond the visible height give nothing
      request_queue.push_back(make_pixel(8'd224, 9'd100, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd255, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      wait_until_drained();

      // Blanked display on 240 lines: black, but still nothing past the bottom
      configure(6'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF);
      request_queue.push_back(make_pixel(8'd239, 9'd0, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd240, 9'd10, 8'h81, 8'h82, 8'h83, 8'h84));
      request_queue.push_back(make_pixel(8'd255, 9'd319, 8'h81, 8'h82, 8'h83, 8'h84));

      // Random phases across register settings; the last one runs without idling
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         wait_until_drained();
         configure(k == 0 ? 6'd0 : (k == RANDOM_PHASES - 1 ? 6'd63 : 6'($urandom_range(0, 63))),
                   k[0], k[1], k % 3 != 1, k == 4, k != 3,
                   k == 0 ? 8'h00 : (k == RANDOM_PHASES - 1 ? 8'hFF : 8'($urandom)),
                   k == 0 ? 8'h00 : (k == RANDOM_PHASES - 1 ? 8'hFF : 8'($urandom)));
         quiet         = (k == RANDOM_PHASES - 1);
         idle_percent  = $urandom_range(0, 2) * 15;
         stall_percent = $urandom_range(0, 2) * 15;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 15)
               request_queue.push_back(make_write(6'($urandom), 12'($urandom)));
            else
               request_queue.push_back(random_pixel());
         end
      end

      wait_until_drained();
      repeat (END_CYCLES) @(negedge clock);
      $display("Run covered %0d pixels checked, %0d color writes, %0d hidden lines, %0d settings",
               pixels_checked, color_writes, hidden_lines, settings_used);
      $display("Input was back-pressured on %0d cycles; long response hold %s",
               input_stalls, hold_done ? "applied" : "not reached");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/spc_pkg.sv
sv/spc_ram.sv
sv/scanline_pixel_compositor.sv
verif/tb_scanline_pixel_compositor.sv
